// File: hw/rtl/tfi_pkg.sv
// shared types, constants and helper functions of the tlsf free list index block
package tfi_pkg;

  // size classing
  localparam int SIZE_BITS      = 32;
  localparam int FL_SHIFT       = 9;
  localparam int SL_BITS        = 4;
  localparam int FL_COUNT       = 23;
  localparam int COUNT_BITS_DEF = 16;

  localparam int SL_COUNT     = 1 << SL_BITS;
  localparam int FL_W         = $clog2(FL_COUNT);
  localparam int SL_W         = SL_BITS;
  localparam int SUM_W        = SIZE_BITS + 1;
  localparam int MSB_W        = $clog2(SUM_W);
  localparam int FLX_W        = MSB_W;
  localparam int FL_MIN_LOG2  = FL_SHIFT + 1;
  localparam int SL_MIN_LOG2  = FL_SHIFT + 1 - SL_BITS;
  localparam int FL_LIMIT     = (FL_COUNT < SIZE_BITS - FL_SHIFT) ? FL_COUNT
                                                                  : SIZE_BITS - FL_SHIFT;
  localparam int CLASS_COUNT  = FL_COUNT * SL_COUNT;
  localparam int ADDR_W       = $clog2(CLASS_COUNT);

  // configuration registers
  localparam int              HEADER_W       = 8;
  localparam logic [7:0]      HEADER_RESET   = 8'd16;
  localparam int              PADDR_W        = 3;
  localparam logic            CFG_IDX_HEADER = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIT    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [4:0] first_level;
    logic [3:0] second_level;
    status_t    status;
  } out_item_t;

  // target class from the classifier
  typedef struct packed {
    logic [FL_W-1:0] fl;
    logic [SL_W-1:0] sl;
    logic            ok;
  } class_t;

  // class picked by the bitmap stage; nz marks a non-empty class
  typedef struct packed {
    logic            nz;
    logic [FL_W-1:0] fl;
    logic [SL_W-1:0] sl;
  } hit_t;

  // bitmap update from the count stage
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [FL_W-1:0] fl;
    logic [SL_W-1:0] sl;
  } map_upd_t;

  // index of the highest set bit
  function automatic logic [MSB_W-1:0] top_bit(input logic [SUM_W-1:0] v);
    logic [MSB_W-1:0] r;
    r = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) r = MSB_W'(i);
    end
    return r;
  endfunction

  // index of the lowest set bit over first levels
  function automatic logic [FL_W-1:0] ffs_fl(input logic [FL_COUNT-1:0] v);
    logic [FL_W-1:0] r;
    r = '0;
    for (int i = FL_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = FL_W'(i);
    end
    return r;
  endfunction

  // index of the lowest set bit over second levels
  function automatic logic [SL_W-1:0] ffs_sl(input logic [SL_COUNT-1:0] v);
    logic [SL_W-1:0] r;
    r = '0;
    for (int i = SL_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = SL_W'(i);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tfi_classify.sv
// size to class mapping with round-up for fit requests
module tfi_classify
  import tfi_pkg::*;
(
  input  cmd_t             cmd,
  input  logic [SUM_W-1:0] value,
  output class_t           cls
);

  logic             big;
  logic [MSB_W-1:0] msb;
  logic [MSB_W-1:0] shamt;
  logic [SUM_W-1:0] shifted;
  logic [SUM_W-1:0] low_bits;
  logic [SL_W-1:0]  sl0;
  logic             low_nz;
  logic             carry;
  logic [FLX_W-1:0] fl_ext;
  logic [FLX_W-1:0] fl_up;

  // leading one and the subclass bits below it
  always_comb begin
    big      = |value[SUM_W-1:FL_MIN_LOG2];
    msb      = top_bit(value);
    shamt    = big ? (msb - MSB_W'(SL_BITS)) : MSB_W'(SL_MIN_LOG2);
    shifted  = value >> shamt;
    sl0      = shifted[SL_W-1:0];
    low_bits = value & ~({SUM_W{1'b1}} << shamt);
    low_nz   = |low_bits;
    fl_ext   = big ? (msb - MSB_W'(FL_SHIFT)) : '0;
    carry    = low_nz && (sl0 == {SL_W{1'b1}});
    fl_up    = fl_ext + FLX_W'(carry);
  end

  // fit rounds up to the next class, insert and remove clamp to the top class
  always_comb begin
    if (cmd == CMD_FIT) begin
      cls.fl = fl_up[FL_W-1:0];
      cls.sl = sl0 + SL_W'(low_nz);
      cls.ok = !value[SUM_W-1] && (fl_up < FLX_W'(FL_LIMIT));
    end else if (fl_ext >= FLX_W'(FL_COUNT)) begin
      cls.fl = FL_W'(FL_COUNT - 1);
      cls.sl = {SL_W{1'b1}};
      cls.ok = 1'b1;
    end else begin
      cls.fl = fl_ext[FL_W-1:0];
      cls.sl = sl0;
      cls.ok = 1'b1;
    end
  end

endmodule

// File: hw/rtl/tfi_bitmap.sv
// two-level occupancy bitmaps and the find-first-set class search
module tfi_bitmap
  import tfi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  map_upd_t upd,
  input  cmd_t     cmd,
  input  class_t   cls,
  output hit_t     hit
);

  logic [FL_COUNT-1:0] l1_r;
  logic [FL_COUNT-1:0] l1_nxt;
  logic [SL_COUNT-1:0] l2_r   [FL_COUNT];
  logic [SL_COUNT-1:0] l2_nxt [FL_COUNT];

  logic [SL_COUNT-1:0] sl_mask;
  logic [SL_COUNT-1:0] word_m [FL_COUNT];
  logic [FL_COUNT-1:0] fl_any;
  logic                found;
  logic [FL_W-1:0]     fl_hit;
  logic [SL_W-1:0]     sl_hit;

  // apply the update of the item in the count stage
  always_comb begin
    l1_nxt = l1_r;
    l2_nxt = l2_r;
    if (upd.set) begin
      l2_nxt[upd.fl][upd.sl] = 1'b1;
      l1_nxt[upd.fl]         = 1'b1;
    end
    if (upd.clr) begin
      l2_nxt[upd.fl][upd.sl] = 1'b0;
      l1_nxt[upd.fl]         = |l2_nxt[upd.fl];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= '0;
      for (int f = 0; f < FL_COUNT; f++) l2_r[f] <= '0;
    end else begin
      l1_r <= l1_nxt;
      l2_r <= l2_nxt;
    end
  end

  // lowest non-empty class at or above the target class
  always_comb begin
    sl_mask = {SL_COUNT{1'b1}} << cls.sl;
    for (int f = 0; f < FL_COUNT; f++) begin
      if (FL_W'(f) == cls.fl) begin
        word_m[f] = l2_nxt[f] & sl_mask;
        fl_any[f] = |word_m[f];
      end else if (FL_W'(f) > cls.fl) begin
        word_m[f] = l2_nxt[f];
        fl_any[f] = l1_nxt[f];
      end else begin
        word_m[f] = '0;
        fl_any[f] = 1'b0;
      end
    end
    found  = |fl_any;
    fl_hit = ffs_fl(fl_any);
    sl_hit = ffs_sl(word_m[fl_hit]);
  end

  // fit takes the found class, insert and remove check their own bit
  always_comb begin
    if (cmd == CMD_FIT) begin
      hit.nz = cls.ok && found;
      hit.fl = fl_hit;
      hit.sl = sl_hit;
    end else begin
      hit.nz = found && (fl_hit == cls.fl) && (sl_hit == cls.sl);
      hit.fl = cls.fl;
      hit.sl = cls.sl;
    end
  end

endmodule

// File: hw/rtl/tfi_count_ram.sv
// per-class free block counts, one write and one registered read port
module tfi_count_ram
  import tfi_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [COUNT_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [COUNT_BITS-1:0] rdata
);

  logic [COUNT_BITS-1:0] mem [CLASS_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tlsf_free_list_index.sv
// top level of the tlsf free list index block
// Takes one command every cycle (busy never rises) and returns exactly one result
// per command in command order, through the input, class, search and output registers.
// The receiver cannot stall: a result is on out_item for the single cycle out_valid
// is high. The pipe is input register, class mapping, bitmap search with count read,
// count update; the bitmap search sees the update of the command just ahead, and
// the count read is forwarded from the write of that command, so throughput is set
// by the loop through the bitmaps. Counts need no clearing after reset: a class
// whose bitmap bit is clear reads as empty. header_bytes sits at address 0.
module tlsf_free_list_index
  import tfi_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  // result channel
  output logic               out_valid,
  output out_item_t          out_item,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [HEADER_W-1:0]   header_r;

  logic                  s1_valid_r;
  cmd_t                  s1_cmd_r;
  logic [SUM_W-1:0]      s1_value_r;
  logic [SUM_W-1:0]      s1_value_nxt;
  class_t                s1_cls;

  logic                  s2_valid_r;
  cmd_t                  s2_cmd_r;
  class_t                s2_cls_r;
  hit_t                  s2_hit;
  logic [ADDR_W-1:0]     s2_raddr;

  logic                  s3_valid_r;
  cmd_t                  s3_cmd_r;
  hit_t                  s3_hit_r;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt;
  logic [ADDR_W-1:0]     s3_waddr;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  map_upd_t              map_upd;
  out_item_t             s3_res;

  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic                  accept;
  logic                  cfg_wr;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_wr && (paddr[2] == CFG_IDX_HEADER)) begin
      header_r <= pwdata[HEADER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_HEADER) prdata = {{(32 - HEADER_W){1'b0}}, header_r};
  end

  // input register, fit requests carry size plus header
  always_comb begin
    s1_value_nxt = {1'b0, in_item.block_size};
    if (in_item.cmd == CMD_FIT) s1_value_nxt = s1_value_nxt + SUM_W'(header_r);
  end

  // class mapping stage
  tfi_classify u_classify (
    .cmd   (s1_cmd_r),
    .value (s1_value_r),
    .cls   (s1_cls)
  );

  // bitmap search stage, also issues the count read
  tfi_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (map_upd),
    .cmd   (s2_cmd_r),
    .cls   (s2_cls_r),
    .hit   (s2_hit)
  );

  assign s2_raddr = ADDR_W'({s2_hit.fl, s2_hit.sl});
  assign s3_waddr = ADDR_W'({s3_hit_r.fl, s3_hit_r.sl});

  tfi_count_ram #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (s3_waddr),
    .wdata (cnt_wdata),
    .raddr (s2_raddr),
    .rdata (ram_rdata)
  );

  // current count, forwarded when the previous command wrote the same class
  always_comb begin
    cnt = '0;
    if (s3_hit_r.nz) cnt = fwd_hit_r ? fwd_data_r : ram_rdata;
  end

  // count update and result
  always_comb begin
    cnt_we              = 1'b0;
    cnt_wdata           = cnt;
    map_upd             = '0;
    map_upd.fl          = s3_hit_r.fl;
    map_upd.sl          = s3_hit_r.sl;
    s3_res.first_level  = '0;
    s3_res.second_level = '0;
    s3_res.status       = ST_OK;
    if (s3_valid_r) begin
      unique case (s3_cmd_r)
        CMD_INSERT: begin
          s3_res.first_level  = 5'(s3_hit_r.fl);
          s3_res.second_level = 4'(s3_hit_r.sl);
          if (cnt == {COUNT_BITS{1'b1}}) begin
            s3_res.status = ST_SATURATED;
          end else begin
            cnt_we      = 1'b1;
            cnt_wdata   = cnt + 1'b1;
            map_upd.set = 1'b1;
          end
        end
        CMD_REMOVE: begin
          s3_res.first_level  = 5'(s3_hit_r.fl);
          s3_res.second_level = 4'(s3_hit_r.sl);
          if (!s3_hit_r.nz) begin
            s3_res.status = ST_EMPTY;
          end else begin
            cnt_we      = 1'b1;
            cnt_wdata   = cnt - 1'b1;
            map_upd.clr = (cnt == COUNT_BITS'(1));
          end
        end
        CMD_FIT: begin
          if (!s3_hit_r.nz) begin
            s3_res.status = ST_NO_FIT;
          end else begin
            s3_res.first_level  = 5'(s3_hit_r.fl);
            s3_res.second_level = 4'(s3_hit_r.sl);
            cnt_we              = 1'b1;
            cnt_wdata           = cnt - 1'b1;
            map_upd.clr         = (cnt == COUNT_BITS'(1));
          end
        end
        CMD_NONE: begin
          s3_res.status = ST_OK;
        end
        default: begin
          s3_res.status = ST_OK;
        end
      endcase
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
      fwd_hit_r   <= cnt_we && (s3_waddr == s2_raddr);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= in_item.cmd;
      s1_value_r <= s1_value_nxt;
    end
    s2_cmd_r   <= s1_cmd_r;
    s2_cls_r   <= s1_cls;
    s3_cmd_r   <= s2_cmd_r;
    s3_hit_r   <= s2_hit;
    fwd_data_r <= cnt_wdata;
    out_item_r <= s3_res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every accepted transaction gives a result at the end of the pipeline
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("result missing four cycles after accept");

  // a class marked non-empty never holds a zero count
  a_count_nz : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_hit_r.nz && (s3_cmd_r == CMD_REMOVE || s3_cmd_r == CMD_FIT))
      |-> (cnt != '0))
    else $error("bitmap and count disagree");

  // an empty-class status only comes from a remove
  a_empty_src : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY)
      |-> $past(accept && in_item.cmd == CMD_REMOVE, 4))
    else $error("empty status without remove");

  // reported first level stays inside the class range
  a_fl_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.first_level < 5'(FL_COUNT)))
    else $error("first level out of range");

endmodule

// File: bench/tb_tlsf_free_list_index.sv
// testbench for the tlsf free list index block: command driver, result monitor and predictor
`timescale 1ns / 1ps

module tb_tlsf_free_list_index;
  import tfi_pkg::*;

  localparam logic [PADDR_W-1:0]  HEADER_ADDR = PADDR_W'(4 * CFG_IDX_HEADER);
  localparam logic [63:0]         SIZE_LIMIT  = 64'hFFFF_FFFF;
  localparam logic [63:0]         FL_MIN      = 64'd1 << FL_MIN_LOG2;
  localparam logic [SL_COUNT-1:0] SL_ALL      = '1;
  localparam logic [FL_COUNT-1:0] FL_ALL      = '1;
  localparam int                  FILL_RUN    = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    cmd_word = '0;
  logic        out_valid;
  out_item_t   result_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tlsf_free_list_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (cmd_word),
    .out_valid (out_valid),
    .out_item  (result_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted index state
  logic [FL_COUNT-1:0]       level_one_bits = '0;
  logic [SL_COUNT-1:0]       level_two_bits [FL_COUNT];
  logic [COUNT_BITS_DEF-1:0] class_counts [CLASS_COUNT];
  logic [7:0]                header_len = HEADER_RESET;

  in_item_t    pending_cmds[$];
  out_item_t   expected_results[$];
  logic [31:0] freed_sizes[$];
  out_item_t   want_item;
  int          err_count = 0;
  int          gap_left = 0;
  int          gap_pct = 0;
  bit          took_cmd = 1'b0;

  initial begin
    for (int f = 0; f < FL_COUNT; f++) level_two_bits[f] = '0;
    for (int c = 0; c < CLASS_COUNT; c++) class_counts[c] = '0;
  end

  function automatic int highest_one(input logic [63:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 64; i++) if (v[i]) r = i;
    return r;
  endfunction

  function automatic int lowest_one(input logic [63:0] v);
    int r;
    r = 0;
    for (int i = 63; i >= 0; i--) if (v[i]) r = i;
    return r;
  endfunction

  // first and second level of a size; false when the first level is out of range
  function automatic bit size_class(input logic [63:0] sz, output int fl, output int sl);
    int msb;
    if (sz < FL_MIN) begin
      fl = 0;
      sl = int'((sz >> SL_MIN_LOG2) & (SL_COUNT - 1));
      return 1'b1;
    end
    msb = highest_one(sz);
    sl = int'((sz >> (msb - SL_BITS)) & (SL_COUNT - 1));
    fl = msb - FL_SHIFT;
    return fl < FL_COUNT;
  endfunction

  // count one block out of a class, clearing map bits when it empties
  function automatic void take_block(input int fl, input int sl);
    int idx;
    idx = fl * SL_COUNT + sl;
    class_counts[idx] = class_counts[idx] - 1'b1;
    if (class_counts[idx] == '0) begin
      level_two_bits[fl][sl] = 1'b0;
      if (level_two_bits[fl] == '0) level_one_bits[fl] = 1'b0;
    end
  endfunction

  // expected result of one command, updating the predicted state
  function automatic out_item_t index_step(input in_item_t it);
    int                  fl, sl, idx;
    status_t             st;
    logic [63:0]         req;
    bit                  ok;
    logic [SL_COUNT-1:0] sl_hits;
    logic [FL_COUNT-1:0] fl_hits;
    out_item_t           r;
    fl = 0;
    sl = 0;
    st = ST_OK;
    case (it.cmd)
      CMD_INSERT, CMD_REMOVE: begin
        // sizes past the last first level land in the top class
        if (!size_class({32'b0, it.block_size}, fl, sl)) begin
          fl = FL_COUNT - 1;
          sl = SL_COUNT - 1;
        end
        idx = fl * SL_COUNT + sl;
        if (it.cmd == CMD_INSERT) begin
          if (&class_counts[idx]) begin
            st = ST_SATURATED;
          end else begin
            class_counts[idx] = class_counts[idx] + 1'b1;
            level_two_bits[fl][sl] = 1'b1;
            level_one_bits[fl] = 1'b1;
          end
        end else if (class_counts[idx] == '0) begin
          st = ST_EMPTY;
        end else begin
          take_block(fl, sl);
        end
      end
      CMD_FIT: begin
        // add the header and round up to the next class boundary
        req = {32'b0, it.block_size} + {56'b0, header_len};
        ok = req <= SIZE_LIMIT;
        if (ok) begin
          if (req >= FL_MIN) req = req + (64'd1 << (highest_one(req) - SL_BITS)) - 1;
          else req = req + (64'd1 << SL_MIN_LOG2) - 1;
          ok = req <= SIZE_LIMIT;
        end
        if (ok) ok = size_class(req, fl, sl);
        // same first level first, then any higher one
        if (ok) begin
          sl_hits = level_two_bits[fl] & (SL_ALL << sl);
          if (sl_hits == '0) begin
            fl_hits = level_one_bits & (FL_ALL << (fl + 1));
            if (fl_hits == '0) begin
              ok = 1'b0;
            end else begin
              fl = lowest_one({{(64 - FL_COUNT){1'b0}}, fl_hits});
              sl_hits = level_two_bits[fl];
              if (sl_hits == '0) ok = 1'b0;
            end
          end
          if (ok) begin
            sl = lowest_one({{(64 - SL_COUNT){1'b0}}, sl_hits});
            if (class_counts[fl * SL_COUNT + sl] == '0) ok = 1'b0;
            else take_block(fl, sl);
          end
        end
        if (!ok) begin
          fl = 0;
          sl = 0;
          st = ST_NO_FIT;
        end
      end
      default: ;
    endcase
    r.first_level = 5'(fl);
    r.second_level = 4'(sl);
    r.status = st;
    return r;
  endfunction

  // command driver with random idle bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if ((took_cmd || !start) && gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
        start <= 1'b0;
        gap_left = $urandom_range(9, 0);
      end else begin
        start <= 1'b1;
        cmd_word <= pending_cmds[0];
      end
    end
  end

  // result monitor: check results, then predict newly accepted commands
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result fl %0d sl %0d status %0d", $time,
                   result_word.first_level, result_word.second_level, result_word.status);
          err_count++;
        end else begin
          want_item = expected_results.pop_front();
          if (result_word.first_level !== want_item.first_level ||
              result_word.second_level !== want_item.second_level ||
              result_word.status !== want_item.status) begin
            $display("%0t: mismatch expected fl %0d sl %0d status %0d, got fl %0d sl %0d status %0d",
                     $time, want_item.first_level, want_item.second_level, want_item.status,
                     result_word.first_level, result_word.second_level, result_word.status);
            err_count++;
          end
        end
      end
      took_cmd = start && !busy;
      if (took_cmd) expected_results.push_back(index_step(pending_cmds.pop_front()));
    end
  end

  task automatic push_cmd(input cmd_t c, input logic [31:0] sz);
    in_item_t it;
    it.cmd = c;
    it.block_size = sz;
    pending_cmds.push_back(it);
  endtask

  // sizes spread over all first levels
  function automatic logic [31:0] pick_size();
    int          msb;
    logic [31:0] top;
    if ($urandom_range(7, 0) == 0) return $urandom();
    msb = $urandom_range(31, 0);
    top = 32'd1 << msb;
    return top | ($urandom() & (top - 32'd1));
  endfunction

  // mostly frees and fits of sizes seen before, with some noise
  task automatic queue_random(input int n);
    int          pick, k;
    logic [31:0] sz;
    repeat (n) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        sz = pick_size();
        push_cmd(CMD_INSERT, sz);
        freed_sizes.push_back(sz);
      end else if (pick < 65) begin
        if (freed_sizes.size() != 0 && $urandom_range(4, 0) != 0) begin
          k = $urandom_range(freed_sizes.size() - 1, 0);
          sz = freed_sizes[k];
          freed_sizes.delete(k);
        end else begin
          sz = pick_size();
        end
        push_cmd(CMD_REMOVE, sz);
      end else if (pick < 95) begin
        if (freed_sizes.size() != 0 && $urandom_range(1, 0) != 0)
          sz = freed_sizes[$urandom_range(freed_sizes.size() - 1, 0)] - $urandom_range(64, 0);
        else
          sz = pick_size();
        push_cmd(CMD_FIT, sz);
      end else begin
        push_cmd(CMD_NONE, $urandom());
      end
    end
  endtask

  // random traffic in chunks, each with its own idle density
  task automatic random_phase(input int n, input bit calm_tail);
    int chunk;
    while (n > 0) begin
      chunk = (n < 50) ? n : 50;
      case ($urandom_range(2, 0))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (calm_tail && n <= 50) gap_pct = 0;
      queue_random(chunk);
      n = n - chunk;
      while (pending_cmds.size() != 0) @(posedge clk);
    end
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write of the header register, setup then access
  task automatic cfg_write(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HEADER_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    header_len = value[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: edges of the size range, overflow, empty class and search order
    gap_pct = 0;
    push_cmd(CMD_FIT, 32'd0);
    push_cmd(CMD_REMOVE, 32'd0);
    push_cmd(CMD_INSERT, 32'd0);
    push_cmd(CMD_INSERT, 32'd1023);
    push_cmd(CMD_INSERT, 32'd1024);
    push_cmd(CMD_INSERT, 32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, 32'h8000_0000);
    push_cmd(CMD_NONE, 32'hFFFF_FFFF);
    push_cmd(CMD_FIT, 32'd0);
    push_cmd(CMD_FIT, 32'd0);
    push_cmd(CMD_FIT, 32'hFFFF_FFFF);
    push_cmd(CMD_FIT, 32'hFFFF_FFEF);
    push_cmd(CMD_FIT, 32'h7FFF_FFF0);
    push_cmd(CMD_FIT, 32'h7FFF_FFF0);
    push_cmd(CMD_REMOVE, 32'd1023);
    push_cmd(CMD_REMOVE, 32'd0);
    push_cmd(CMD_INSERT, 32'd511);
    push_cmd(CMD_FIT, 32'd100);
    push_cmd(CMD_FIT, 32'h0040_0000);
    push_cmd(CMD_INSERT, 32'h5A5A_5A5A);
    push_cmd(CMD_REMOVE, 32'h5A5A_5A5A);
    push_cmd(CMD_NONE, 32'd0);
    settle();

    // fill the top class back to back, then drain it one past empty
    for (int i = 0; i < FILL_RUN; i++) push_cmd(CMD_INSERT, 32'hF800_0000 | ($urandom() >> 5));
    for (int i = 0; i <= FILL_RUN; i++) push_cmd(CMD_REMOVE, 32'hF800_0000 | ($urandom() >> 5));
    settle();

    cfg_write(32'd0);
    random_phase(135, 1'b0);
    settle();

    cfg_write(32'd255);
    random_phase(135, 1'b0);
    settle();

    cfg_write($urandom_range(254, 1));
    random_phase(135, 1'b1);
    settle();

    if (err_count == 0) begin
      $display("tlsf_free_list_index test passed");
    end else begin
      $display("tlsf_free_list_index test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tlsf_free_list_index test failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tfi_pkg.sv
hw/rtl/tfi_classify.sv
hw/rtl/tfi_bitmap.sv
hw/rtl/tfi_count_ram.sv
hw/rtl/tlsf_free_list_index.sv
bench/tb_tlsf_free_list_index.sv
